// ===== sv/tcma_pkg.sv =====
// Shared types and constants for the two-channel moving-average block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcma_pkg;

    // Averaging window length per channel.
    localparam int WINDOW = 10;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 10;
    localparam int REF_W    = 13;
    localparam int MV_W     = 13;

    localparam logic [CH_W-1:0]  CH_FIRST  = 3'd0;
    localparam logic [CH_W-1:0]  CH_SECOND = 3'd7;
    localparam logic [REF_W-1:0] REF_RESET = 13'd5000;

    // Scaling by the converter full scale of 1024 codes is a right shift.
    localparam int FS_SHIFT = 10;

    localparam int POS_W      = $clog2(WINDOW);
    localparam int RING_DEPTH = 2 * WINDOW;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int SUM_W      = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    // Floor division by WINDOW as a multiply by a rounded-up reciprocal.
    // With DIV_K = SUM_W + clog2(WINDOW) the quotient is exact for every sum.
    localparam int DIV_K   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = DIV_K;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_K) + WINDOW - 1) / WINDOW);
    localparam int QPROD_W = SUM_W + RECIP_W;
    localparam int SPROD_W = SAMPLE_W + REF_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                filt;
        logic                ring;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    // Back-end status toward the queue and the top level.
    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== sv/tcma_front.sv =====
// Input stage: takes transfers, classifies the channel and holds the item
// until the queue has room. Depends on tcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcma_front
    import tcma_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic                     o_push,
    output t_item                    o_item,
    input  wire logic                i_q_full
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;
    assign take       = i_in_valid && o_in_ready;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.filt   <= (i_channel == CH_FIRST) || (i_channel == CH_SECOND);
            r_item.ring   <= (i_channel == CH_SECOND);
            r_item.sample <= i_sample;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcma_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on tcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcma_queue
    import tcma_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_slot [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcma_back.sv =====
// Execution stage: for a filtered item updates the sample ring and running sum
// of its channel, divides by the window, scales to millivolts and holds the result; an unfiltered item gives zero.
// Depends on tcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcma_back
    import tcma_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_item            i_q_item,
    output t_back_stat            o_stat,
    input  wire logic [REF_W-1:0] i_ref_mv,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [MV_W-1:0]       o_millivolts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SCALE
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic [MV_W-1:0]      r_out_mv;
    logic [POS_W-1:0]     r_pos [0:1];
    logic [SUM_W-1:0]     r_sum [0:1];
    logic [RING_DEPTH-1:0] r_mem_ok;

    logic [SAMPLE_W-1:0]  r_mem [0:RING_DEPTH-1];
    logic [SAMPLE_W-1:0]  r_rd_data;
    logic                 r_rd_ok;
    t_item                r_item;
    logic [ADDR_W-1:0]    r_addr;
    logic [SUM_W-1:0]     r_acc;
    logic [QPROD_W-1:0]   r_qprod;

    logic                 pop;
    logic                 slot_free;
    logic                 out_load;
    logic [ADDR_W-1:0]    rd_addr;
    logic [POS_W-1:0]     head_pos;
    logic [SAMPLE_W-1:0]  old_sample;
    logic [SUM_W-1:0]     n_sum;
    logic [POS_W-1:0]     n_pos;
    logic [SAMPLE_W-1:0]  avg;
    logic [SPROD_W-1:0]   sprod;
    logic                 mem_we;

    assign slot_free = !r_out_valid || i_out_ready;
    assign pop       = (r_state == ST_IDLE) && i_q_valid && slot_free;
    assign mem_we    = (r_state == ST_ACC);

    // The output register loads a zero for an unfiltered item or a scaled average.
    assign out_load  = (pop && !i_q_item.filt) || (r_state == ST_SCALE);

    assign head_pos = r_pos[i_q_item.ring];
    assign rd_addr  = i_q_item.ring ? ADDR_W'(WINDOW) + ADDR_W'(head_pos) : ADDR_W'(head_pos);

    // Entries never written since reset count as zero.
    assign old_sample = r_rd_ok ? r_rd_data : '0;
    assign n_sum      = r_sum[r_item.ring] - SUM_W'(old_sample) + SUM_W'(r_item.sample);
    assign n_pos      = (r_pos[r_item.ring] == POS_W'(WINDOW - 1)) ? '0
                                                                  : r_pos[r_item.ring] + 1'b1;

    assign avg   = r_qprod[DIV_K +: SAMPLE_W];
    assign sprod = SPROD_W'(avg) * SPROD_W'(i_ref_mv);

    assign o_stat.pop    = pop;
    assign o_stat.busy   = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_millivolts  = r_out_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_out_mv    <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_mem_ok    <= '0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        if (i_q_item.filt) begin
                            r_state <= ST_ACC;
                        end else begin
                            r_out_mv <= '0;
                        end
                    end
                end
                ST_ACC: begin
                    r_sum[r_item.ring] <= n_sum;
                    r_pos[r_item.ring] <= n_pos;
                    r_mem_ok[r_addr]   <= 1'b1;
                    r_state            <= ST_DIV;
                end
                ST_DIV: begin
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_out_mv    <= sprod[FS_SHIFT +: MV_W];
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Ring memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_item.sample;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_mem_ok[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_q_item;
            r_addr <= rd_addr;
        end
        if (r_state == ST_ACC) begin
            r_acc <= n_sum;
        end
        if (r_state == ST_DIV) begin
            r_qprod <= QPROD_W'(r_acc) * QPROD_W'(RECIP);
        end
    end

endmodule

`default_nettype wire

// ===== sv/two_channel_moving_average_millivolts.sv =====
// Top level: the item for channel 0 or 7 is averaged over its last window
// of samples and scaled to millivolts; other channels give zero at once.
// A filtered item runs the back-end sequence of ring read, sum update,
// reciprocal divide and scaling before the back end takes the next item;
// other channels pass at one per cycle while the output is not stalled.
// Synchronous active-low reset; rings read as zero.
`timescale 1ns / 1ps
`default_nettype none

module two_channel_moving_average_millivolts
    import tcma_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [REF_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [MV_W-1:0]          o_millivolts
);

    logic [REF_W-1:0] r_ref_mv;
    logic             fr_push;
    t_item            fr_item;
    logic             q_full;
    logic             q_valid;
    t_item            q_item;
    t_back_stat       bk_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv <= REF_RESET;
        end else if (i_cfg_we) begin
            r_ref_mv <= i_cfg_data;
        end
    end

    tcma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_channel  (i_channel),
        .i_sample   (i_sample),
        .o_push     (fr_push),
        .o_item     (fr_item),
        .i_q_full   (q_full)
    );

    tcma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (bk_stat.pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tcma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_stat       (bk_stat),
        .i_ref_mv     (r_ref_mv),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_millivolts (o_millivolts)
    );

    // The back end never takes an item from an empty queue.
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.pop |-> q_valid)
        else $error("back end popped an empty queue");

    // A filtered item keeps the back end busy after it is taken.
    a_filtered_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bk_stat.pop && q_item.filt) |=> bk_stat.busy)
        else $error("filtered item did not start the back-end sequence");

    // An unfiltered channel shows a zero result in the next cycle.
    a_unfiltered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bk_stat.pop && !q_item.filt) |=> (o_out_valid && (o_millivolts == '0)))
        else $error("unfiltered channel did not return zero");

endmodule

`default_nettype wire
